@@ hdl/crs_pkg.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom segment evaluator: shared package
// Widths, codes and control types used by the evaluator and its submodules.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int AXES       = 3;
    localparam int WIN_DEPTH  = 4;
    localparam int COORD_W    = 16;  // point and position coordinate
    localparam int T_W        = 16;  // curve parameter, unsigned Q0.16
    localparam int D1_W       = 17;  // P2 - P0
    localparam int D_W        = 20;  // doubled quadratic and cubic coefficients
    localparam int OPND_W     = 38;  // multiplicand held between passes
    localparam int LO_W       = 19;  // low multiplicand chunk, unsigned
    localparam int CHUNK_W    = 20;  // signed chunk fed to the multiplier
    localparam int MUL_W      = 37;  // product of T and one chunk
    localparam int ACC_W      = 55;  // Horner accumulator
    localparam int POS_SHIFT  = 33;
    localparam int POS_W      = ACC_W - POS_SHIFT;
    localparam int R1_SHIFT   = 16;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_FIRST = 2'd0;
    localparam t_axis AXIS_LAST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MLO,
        ST_MHI,
        ST_WAIT
    } t_state;

    // Horner passes: s2, then s1, then s0.
    typedef enum logic [1:0] {
        STG_S2,
        STG_S1,
        STG_S0
    } t_stage;

    typedef struct packed {
        logic load;  // accumulator takes the preload value
        logic step;  // accumulator takes the running sum
        logic hi;    // multiply the high chunk, weighted by 2^19
    } t_mac_ctrl;

endpackage

@@ hdl/crs_window.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom control point window
// Four-point shift window and the per-axis doubled spline coefficients.
// ----------------------------------------------------------------------------
module crs_window import crs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    input  logic signed [COORD_W-1:0] i_z,
    input  t_axis                     i_axis,
    output logic signed [D1_W-1:0]    o_d1,
    output logic signed [D_W-1:0]     o_d2,
    output logic signed [D_W-1:0]     o_d3,
    output logic signed [COORD_W-1:0] o_p1
);

    logic signed [COORD_W-1:0] r_win [WIN_DEPTH][AXES];
    logic signed [COORD_W-1:0] w_p [WIN_DEPTH];
    logic signed [D_W-1:0]     w_e0, w_e1, w_e2, w_e3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                for (int a = 0; a < AXES; a++) begin
                    r_win[i][a] <= '0;
                end
            end
        end else if (i_push) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                for (int a = 0; a < AXES; a++) begin
                    r_win[i][a] <= r_win[i+1][a];
                end
            end
            r_win[WIN_DEPTH-1][0] <= i_x;
            r_win[WIN_DEPTH-1][1] <= i_y;
            r_win[WIN_DEPTH-1][2] <= i_z;
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            unique case (i_axis)
                2'd0:    w_p[i] = r_win[i][0];
                2'd1:    w_p[i] = r_win[i][1];
                2'd2:    w_p[i] = r_win[i][2];
                default: w_p[i] = '0;
            endcase
        end
    end

    assign w_e0 = D_W'(w_p[0]);
    assign w_e1 = D_W'(w_p[1]);
    assign w_e2 = D_W'(w_p[2]);
    assign w_e3 = D_W'(w_p[3]);

    assign o_d1 = D1_W'(w_p[2]) - D1_W'(w_p[0]);
    // 2P0 - 5P1 + 4P2 - P3 and -P0 + 3P1 - 3P2 + P3, all exact in 20 bits.
    assign o_d2 = (w_e0 <<< 1) - (w_e1 <<< 2) - w_e1 + (w_e2 <<< 2) - w_e3;
    assign o_d3 = (w_e1 <<< 1) + w_e1 - (w_e2 <<< 1) - w_e2 + w_e3 - w_e0;
    assign o_p1 = w_p[1];

endmodule

@@ hdl/crs_mac.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom shared multiply-accumulate unit
// One 17x20 signed multiplier and the Horner accumulator it feeds.
// ----------------------------------------------------------------------------
module crs_mac import crs_pkg::*; (
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic        [T_W-1:0]    i_t,
    input  logic signed [OPND_W-1:0] i_opnd,
    input  logic signed [ACC_W-1:0]  i_load_val,
    output logic signed [ACC_W-1:0]  o_sum
);

    logic signed [ACC_W-1:0]   r_acc;
    logic signed [CHUNK_W-1:0] w_chunk;
    logic signed [MUL_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]   w_term;

    // The multiplicand is split into an unsigned low chunk and a signed high chunk.
    assign w_chunk = i_ctrl.hi ? {i_opnd[OPND_W-1], i_opnd[OPND_W-1:LO_W]}
                               : {1'b0, i_opnd[LO_W-1:0]};
    assign w_prod  = MUL_W'($signed({1'b0, i_t})) * MUL_W'(w_chunk);
    assign w_term  = i_ctrl.hi ? (ACC_W'(w_prod) <<< LO_W) : ACC_W'(w_prod);
    assign o_sum   = r_acc + w_term;

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.load) begin
            r_acc <= i_load_val;
        end else if (i_ctrl.step) begin
            r_acc <= o_sum;
        end
    end

endmodule

@@ hdl/catmull_rom_segment_eval_unit.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom segment evaluation unit
// Uniform Catmull-Rom spline evaluator for 3-D points in signed fixed point.
// ----------------------------------------------------------------------------
//  Port group  Dir  tdata (low bit up)                     tuser
//  s_axis      in   point_x, point_y, point_z, param_t     opcode
//  m_axis      out  pos_x, pos_y, pos_z                    saturated
//
//  A push item is taken and gives no result.
//  An evaluate item runs three Horner passes per axis on one shared multiplier,
//  each pass split over a low and a high multiplicand chunk, after a load step
//  for that axis. After the last axis the result is loaded into the output register, and the
//  input is ready again in the cycle after; a result still waiting holds it off.
//  The output register lets the next item in while a result waits to be taken.
//  Synchronous active-low reset clears the control point window to zeros.
// ----------------------------------------------------------------------------
module catmull_rom_segment_eval_unit import crs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // point_x, point_y, point_z, param_t
    input  logic                  s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pos_x, pos_y, pos_z
    output logic                  m_axis_tuser    // saturated
);

    t_state                    r_state, n_state;
    t_stage                    r_stage;
    t_axis                     r_axis;
    logic        [T_W-1:0]     r_t;
    logic signed [OPND_W-1:0]  r_opnd;
    logic signed [COORD_W-1:0] r_pos [AXES];
    logic                      r_clip;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic                      r_out_user;
    logic                      r_out_valid;

    logic                      w_in_acc;
    logic                      w_push;
    logic                      w_start;
    t_mac_ctrl                 w_mac_ctrl;
    logic signed [ACC_W-1:0]   w_load_val;
    logic                      w_opnd_load;
    logic signed [OPND_W-1:0]  w_opnd_val;
    logic                      w_pos_wr;
    logic                      w_out_load;
    logic signed [ACC_W-1:0]   w_sum;
    logic signed [D1_W-1:0]    w_d1;
    logic signed [D_W-1:0]     w_d2, w_d3;
    logic signed [COORD_W-1:0] w_p1;
    logic signed [POS_W-1:0]   w_pos_full;
    logic [POS_W-COORD_W:0]    w_pos_top;
    logic                      w_clip;
    logic signed [COORD_W-1:0] w_pos_sat;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_push        = w_in_acc && (s_axis_tuser == OP_PUSH);
    assign w_start       = w_in_acc && (s_axis_tuser == OP_EVAL);

    crs_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_x     (s_axis_tdata[COORD_W-1:0]),
        .i_y     (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_z     (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .i_axis  (r_axis),
        .o_d1    (w_d1),
        .o_d2    (w_d2),
        .o_d3    (w_d3),
        .o_p1    (w_p1)
    );

    crs_mac u_mac (
        .i_clk      (i_clk),
        .i_ctrl     (w_mac_ctrl),
        .i_t        (r_t),
        .i_opnd     (r_opnd),
        .i_load_val (w_load_val),
        .o_sum      (w_sum)
    );

    // The final pass preloads the rounding constant, so the position is a plain slice.
    assign w_pos_full = w_sum[ACC_W-1:POS_SHIFT];
    assign w_pos_top  = w_pos_full[POS_W-1:COORD_W-1];
    assign w_clip     = !((&w_pos_top) || !(|w_pos_top));
    assign w_pos_sat  = w_clip ? (w_pos_full[POS_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                                      : {1'b0, {(COORD_W-1){1'b1}}})
                               : w_pos_full[COORD_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_MLO;
            ST_MLO:  n_state = ST_MHI;
            ST_MHI: begin
                if (r_stage == STG_S0) begin
                    n_state = (r_axis == AXIS_LAST) ? ST_WAIT : ST_LOAD;
                end else begin
                    n_state = ST_MLO;
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_mac_ctrl  = '0;
        w_load_val  = '0;
        w_opnd_load = 1'b0;
        w_opnd_val  = '0;
        w_pos_wr    = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: ;
            ST_LOAD: begin
                // s2 starts from d2 * 2^16; d3 is the first multiplicand.
                w_mac_ctrl.load = 1'b1;
                w_load_val      = {{(ACC_W-D_W-16){w_d2[D_W-1]}}, w_d2, 16'h0000};
                w_opnd_load     = 1'b1;
                w_opnd_val      = OPND_W'(w_d3);
            end
            ST_MLO: begin
                w_mac_ctrl.step = 1'b1;
            end
            ST_MHI: begin
                w_mac_ctrl.hi = 1'b1;
                unique case (r_stage)
                    STG_S2: begin
                        // s1 starts from d1 * 2^32 plus the half LSB of r1.
                        w_mac_ctrl.load = 1'b1;
                        w_load_val      = {{(ACC_W-D1_W-32){w_d1[D1_W-1]}}, w_d1,
                                           32'h0000_8000};
                        w_opnd_load     = 1'b1;
                        w_opnd_val      = w_sum[OPND_W-1:0];
                    end
                    STG_S1: begin
                        // s0 starts from 2*P1 * 2^32 plus the half LSB of the position.
                        w_mac_ctrl.load = 1'b1;
                        w_load_val      = {{(ACC_W-COORD_W-33){w_p1[COORD_W-1]}}, w_p1,
                                           1'b1, 32'h0000_0000};
                        w_opnd_load     = 1'b1;
                        w_opnd_val      = w_sum[OPND_W+R1_SHIFT-1:R1_SHIFT];
                    end
                    STG_S0: begin
                        w_pos_wr = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_WAIT: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stage     <= STG_S2;
            r_axis      <= AXIS_FIRST;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_axis <= AXIS_FIRST;
                r_clip <= 1'b0;
            end
            if (r_state == ST_LOAD) begin
                r_stage <= STG_S2;
            end else if (r_state == ST_MHI) begin
                unique case (r_stage)
                    STG_S2:  r_stage <= STG_S1;
                    STG_S1:  r_stage <= STG_S0;
                    STG_S0:  r_stage <= STG_S2;
                    default: r_stage <= STG_S2;
                endcase
            end
            if (w_pos_wr) begin
                r_clip <= r_clip || w_clip;
                if (r_axis != AXIS_LAST) r_axis <= r_axis + 2'd1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) r_t <= s_axis_tdata[3*COORD_W+T_W-1:3*COORD_W];
        if (w_opnd_load) r_opnd <= w_opnd_val;
        if (w_pos_wr) begin
            for (int a = 0; a < AXES; a++) begin
                if (r_axis == t_axis'(a)) r_pos[a] <= w_pos_sat;
            end
        end
        if (w_out_load) begin
            r_out_data <= {r_pos[2], r_pos[1], r_pos[0]};
            r_out_user <= r_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == ST_LOAD) && (r_axis == AXIS_FIRST) && !r_clip)
        else $error("evaluate item did not start at the first axis");

    a_push_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_state == ST_IDLE))
        else $error("push item left the idle state");

    a_out_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_WAIT))
        else $error("result appeared outside the hand-off state");

    a_mlo_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MLO) |-> (($past(r_state) == ST_LOAD) || ($past(r_state) == ST_MHI)))
        else $error("low multiply pass entered out of order");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= AXIS_LAST)
        else $error("axis counter out of range");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Catmull-Rom segment evaluation unit testbench
// Streams control point pushes and curve evaluations into the unit and checks
// every position against a bit-exact fixed-point Horner predictor, under
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top import crs_pkg::*;;

    typedef struct packed {
        logic             op;
        logic [15:0]      t;
        logic [2:0][15:0] pt;   // z, y, x
    } t_curve_item;

    typedef struct packed {
        logic             sat;
        logic [2:0][15:0] pos;  // z, y, x
    } t_position;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // point_x, point_y, point_z, param_t
    logic                  s_axis_tuser = 1'b0; // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // pos_x, pos_y, pos_z
    logic                  m_axis_tuser;        // saturated

    t_curve_item      pending_items[$];
    t_position        expected_positions[$];
    logic [2:0][15:0] window_pts [WIN_DEPTH];
    t_position        due_position;
    t_curve_item      next_item;
    logic             item_taken = 1'b0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               items_queued = 0;
    int               push_count = 0;
    int               eval_count = 0;
    int               clipped_count = 0;
    int               mismatch_count = 0;

    catmull_rom_segment_eval_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("%0t: run timed out with %0d items pending and %0d results due",
                 $realtime, pending_items.size(), expected_positions.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Position on the current window at t, Horner's rule on doubled coefficients.
    function automatic t_position catmull_rom_position(input logic [15:0] t_raw);
        t_position res;
        longint    t, p0, p1, p2, p3, d1, d2, d3, s2, s1, r1, s0, pos;
        res = '0;
        t = longint'({48'd0, t_raw});
        for (int a = 0; a < AXES; a++) begin
            p0 = longint'($signed(window_pts[0][a]));
            p1 = longint'($signed(window_pts[1][a]));
            p2 = longint'($signed(window_pts[2][a]));
            p3 = longint'($signed(window_pts[3][a]));
            d1 = p2 - p0;
            d2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            d3 = -p0 + 3 * p1 - 3 * p2 + p3;
            s2 = (d2 <<< 16) + t * d3;
            s1 = (d1 <<< 32) + t * s2;
            r1 = (s1 + 32768) >>> 16;
            s0 = (p1 <<< 33) + t * r1;
            pos = (s0 + (longint'(1) <<< 32)) >>> 33;
            if (pos > 32767) begin
                pos = 32767;
                res.sat = 1'b1;
            end else if (pos < -32768) begin
                pos = -32768;
                res.sat = 1'b1;
            end
            res.pos[a] = 16'(pos);
        end
        return res;
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            1, 2, 3: return 16'($urandom_range(4095)) - 16'd2048;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_t();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic op, input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic [15:0] t);
        t_curve_item it;
        it.op = op;
        it.t  = t;
        it.pt = {z, y, x};
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Mostly a few pushes followed by evaluations; now and then a stray item.
    task automatic queue_curve_burst();
        int n_push;
        int n_eval;
        if ($urandom_range(99) < 15) begin
            queue_item($urandom_range(1) ? OP_EVAL : OP_PUSH, 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            n_push = $urandom_range(1, 4);
            n_eval = $urandom_range(1, 3);
            repeat (n_push)
                queue_item(OP_PUSH, pick_coord(), pick_coord(), pick_coord(),
                           16'($urandom));
            repeat (n_eval)
                queue_item(OP_EVAL, 16'($urandom), 16'($urandom), 16'($urandom),
                           pick_t());
        end
    endtask

    task automatic wait_all_done();
        while (pending_items.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_positions.size() != 0) @(posedge i_clk);
    endtask

    // Sender side: a new item goes out once the previous one was taken; the receiver ready is drawn here too.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || item_taken) begin
                if (pending_items.size() == 0 || $urandom_range(99) < send_idle_pct) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_item.t, next_item.pt};
                    s_axis_tuser  <= next_item.op;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) window_pts[i] = '0;
        end else begin
            item_taken <= s_axis_tvalid && s_axis_tready;
            // Results are checked before this edge's input, which cannot be due yet.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_positions.size() == 0) begin
                    $display("%0t: result with none due, actual pos %h sat %b",
                             $realtime, m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    due_position = expected_positions.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        if (m_axis_tdata[16*a +: 16] !== due_position.pos[a]) begin
                            $display("%0t: axis %0d position expected %h actual %h",
                                     $realtime, a, due_position.pos[a],
                                     m_axis_tdata[16*a +: 16]);
                            mismatch_count++;
                        end
                    end
                    if (m_axis_tuser !== due_position.sat) begin
                        $display("%0t: saturated flag expected %b actual %b",
                                 $realtime, due_position.sat, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == OP_PUSH) begin
                    for (int i = 0; i < WIN_DEPTH - 1; i++) window_pts[i] = window_pts[i + 1];
                    window_pts[WIN_DEPTH - 1] = s_axis_tdata[47:0];
                    push_count++;
                end else begin
                    due_position = catmull_rom_position(s_axis_tdata[63:48]);
                    if (due_position.sat) clipped_count++;
                    expected_positions.push_back(due_position);
                    eval_count++;
                end
            end
        end
    end

    initial begin
        int phase_start;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Evaluations on a partly filled window, where unpushed points are zero.
        queue_item(OP_EVAL, 16'h1234, 16'hfedc, 16'h8001, 16'h0000);
        queue_item(OP_PUSH, 16'h0100, 16'hff00, 16'h0080, 16'hffff);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
        queue_item(OP_PUSH, 16'h0300, 16'h0200, 16'hfe00, 16'h0000);
        queue_item(OP_EVAL, 16'hffff, 16'hffff, 16'hffff, 16'h8000);
        queue_item(OP_PUSH, 16'h0500, 16'hfa00, 16'h0001, 16'h5555);
        queue_item(OP_PUSH, 16'h0700, 16'h0000, 16'hffff, 16'haaaa);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        // Alternating full-scale points drive the curve past the 16-bit range.
        queue_item(OP_PUSH, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
        queue_item(OP_PUSH, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
        queue_item(OP_PUSH, 16'h7fff, 16'h8000, 16'hffff, 16'h0000);
        queue_item(OP_PUSH, 16'h8000, 16'h7fff, 16'h8000, 16'h0000);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
        queue_item(OP_PUSH, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
        queue_item(OP_PUSH, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        queue_item(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'hc000);
        wait_all_done();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 7;  recv_idle_pct = 65; end
                1: begin send_idle_pct = 65; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_start = items_queued;
            while (items_queued - phase_start < 645) queue_curve_burst();
            // Sender holds off here until every result of the phase is back.
            wait_all_done();
        end

        repeat (40) @(posedge i_clk);
        $display("Covered %0d pushes and %0d evaluations over three idling patterns;",
                 push_count, eval_count);
        $display("%0d positions came back clipped to the coordinate range.", clipped_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
